FILE: rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Widths, types and helpers shared by the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int FRAC_BITS = 16;               // fractional bits of hue and saturation
  localparam int CH_W      = 8;                // channel byte width
  localparam int OUT_W     = 16;               // hue and saturation port width
  localparam int N_W       = 11;               // sector numerator, up to 6 * 255
  localparam int DSR_W     = 12;               // divisor, up to 12 * 255
  localparam int REM_W     = DSR_W;            // partial remainder
  localparam int QUO_W     = FRAC_BITS + 1;    // quotient reaches one full turn
  localparam int DVD_W     = FRAC_BITS + DSR_W;
  localparam int QDEPTH    = 2;
  localparam int PTR_W     = $clog2(QDEPTH);

  // one classified pixel waiting for division
  typedef struct packed {
    logic [DVD_W-1:0] hue_dvd;
    logic [DSR_W-1:0] hue_dsr;
    logic [DVD_W-1:0] sat_dvd;
    logic [DSR_W-1:0] sat_dsr;
    logic             grey;
    logic             black;
    logic [CH_W-1:0]  value;
  } entry_t;

  // sideband that travels beside the dividers
  typedef struct packed {
    logic            grey;
    logic            black;
    logic [CH_W-1:0] value;
  } side_t;

  // low OUT_W bits of a fraction, zero extended when it is narrower
  function automatic logic [OUT_W-1:0] fit_out(input logic [FRAC_BITS-1:0] frac);
    logic [FRAC_BITS+OUT_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, frac};
    return ext[OUT_W-1:0];
  endfunction

endpackage

FILE: rtl/rgbhsv_if.sv
// ----------------------------------------------------------------------------
// rgbhsv_if
// Valid/ready channels for pixels in and hue, saturation, value out.
// ----------------------------------------------------------------------------
interface rgbhsv_pix_if;
  import rgbhsv_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if;
  import rgbhsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] hue;
  logic [OUT_W-1:0] saturation;
  logic [CH_W-1:0]  value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

FILE: rtl/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// Accepts a pixel, finds max and min, picks the hue sector and forms the
// dividends and divisors for hue and saturation.
// ----------------------------------------------------------------------------
module rgbhsv_front (
  rgbhsv_pix_if.sink           pix_i,
  input  logic                 q_ready_i,
  output logic                 push_o,
  output rgbhsv_pkg::entry_t   entry_o
);
  import rgbhsv_pkg::*;

  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;
  logic [CH_W-1:0] d;
  logic [N_W-1:0]  d_n;
  logic [N_W-1:0]  n;
  logic            blue_max;
  logic            green_max;

  assign pix_i.ready = q_ready_i;
  assign push_o      = pix_i.valid && q_ready_i;

  // ties go to blue, then green
  assign blue_max  = (pix_i.blue >= pix_i.red) && (pix_i.blue >= pix_i.green);
  assign green_max = !blue_max && (pix_i.green >= pix_i.red);

  always_comb begin
    mx = pix_i.red;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.blue > mx) mx = pix_i.blue;
    mn = pix_i.red;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.blue < mn) mn = pix_i.blue;
  end

  assign d   = mx - mn;
  assign d_n = N_W'(d);

  // numerator lands in 0 .. 6d, so modular arithmetic at N_W bits is exact
  always_comb begin
    if (blue_max) begin
      n = N_W'(pix_i.red) - N_W'(pix_i.green) + (d_n << 2);
    end else if (green_max) begin
      n = N_W'(pix_i.blue) - N_W'(pix_i.red) + (d_n << 1);
    end else begin
      n = N_W'(pix_i.green) - N_W'(pix_i.blue);
      if (pix_i.green < pix_i.blue) n = n + (d_n << 2) + (d_n << 1);
    end
  end

  always_comb begin
    entry_o.hue_dvd = {n, {(FRAC_BITS + 1){1'b0}}} + DVD_W'((d_n << 2) + (d_n << 1));
    entry_o.hue_dsr = (DSR_W'(d) << 3) + (DSR_W'(d) << 2);
    entry_o.sat_dvd = DVD_W'({d, {(FRAC_BITS + 1){1'b0}}}) + DVD_W'(mx);
    entry_o.sat_dsr = DSR_W'({mx, 1'b0});
    entry_o.grey    = (d == '0);
    entry_o.black   = (mx == '0);
    entry_o.value   = mx;
  end

endmodule

FILE: rtl/rgbhsv_queue.sv
// ----------------------------------------------------------------------------
// rgbhsv_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module rgbhsv_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rgbhsv_pkg::entry_t   entry_i,
  output logic                 ready_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output rgbhsv_pkg::entry_t   entry_o
);
  import rgbhsv_pkg::*;

  entry_t           slot_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  assign ready_o = (cnt_q != (PTR_W + 1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= entry_i;
  end

endmodule

FILE: rtl/rgbhsv_div.sv
// ----------------------------------------------------------------------------
// rgbhsv_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgbhsv_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rgbhsv_pkg::DVD_W-1:0]  dividend_i,
  input  logic [rgbhsv_pkg::DSR_W-1:0]  divisor_i,
  output logic [rgbhsv_pkg::QUO_W-1:0]  quotient_o
);
  import rgbhsv_pkg::*;

  logic [REM_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DSR_W-1:0] dsr_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DSR_W-1:0] dsr_in;
    logic [REM_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      // upper dividend bits are already below the divisor since quotient < 2^QUO_W
      assign rem_in = REM_W'(dividend_i[DVD_W-1:QUO_W]);
      assign low_in = dividend_i[QUO_W-1:0];
      assign quo_in = '0;
      assign dsr_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dsr_in = dsr_q[k-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign ge    = (trial >= {1'b0, dsr_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? REM_W'(trial - {1'b0, dsr_in}) : REM_W'(trial);
        low_q[k] <= {low_in[QUO_W-2:0], 1'b0};
        quo_q[k] <= {quo_in[QUO_W-2:0], ge};
        dsr_q[k] <= dsr_in;
      end
    end
  end

  assign quotient_o = quo_q[QUO_W-1];

endmodule

FILE: rtl/rgbhsv_back.sv
// ----------------------------------------------------------------------------
// rgbhsv_back
// Runs hue and saturation divisions in lockstep and drives the result
// channel from the last stage.
// ----------------------------------------------------------------------------
module rgbhsv_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  rgbhsv_pkg::entry_t   q_entry_i,
  output logic                 q_pop_o,
  rgbhsv_hsv_if.source         hsv_o
);
  import rgbhsv_pkg::*;

  logic [QUO_W-1:0] vld_q;
  side_t            side_q [QUO_W];
  logic             en;
  logic [QUO_W-1:0] hue_quo;
  logic [QUO_W-1:0] sat_quo;
  side_t            side_out;

  // whole pipe advances unless the finished request is held
  assign en      = !vld_q[QUO_W-1] || hsv_o.ready;
  assign q_pop_o = q_valid_i && en;

  rgbhsv_div u_hue_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (q_entry_i.hue_dvd),
    .divisor_i  (q_entry_i.hue_dsr),
    .quotient_o (hue_quo)
  );

  rgbhsv_div u_sat_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (q_entry_i.sat_dvd),
    .divisor_i  (q_entry_i.sat_dsr),
    .quotient_o (sat_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[QUO_W-2:0], q_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{grey: q_entry_i.grey, black: q_entry_i.black, value: q_entry_i.value};
      for (int k = 1; k < QUO_W; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_out = side_q[QUO_W-1];

  always_comb begin
    hsv_o.valid = vld_q[QUO_W-1];
    hsv_o.value = side_out.value;
    // full turn wraps to zero by dropping the top quotient bit
    hsv_o.hue   = side_out.grey ? '0 : fit_out(hue_quo[FRAC_BITS-1:0]);
    if (side_out.black) begin
      hsv_o.saturation = '0;
    end else if (sat_quo[FRAC_BITS]) begin
      hsv_o.saturation = fit_out('1);
    end else begin
      hsv_o.saturation = fit_out(sat_quo[FRAC_BITS-1:0]);
    end
  end

endmodule

FILE: rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGB pixel to hue, saturation, value, one pixel per clock if not stalled.
//
//   channel   dir   handshake      payload
//   pix_i     in    valid/ready    red, green, blue (8 bits each)
//   hsv_o     out   valid/ready    hue (16), saturation (16), value (8)
//
// while results are taken, a new pixel can be taken every clock and
// throughput is one per cycle; a pixel is registered in the queue, then
// in each pipelined stage of the two dividers
// reset clears the queue pointers and count and the pipeline valid bits,
// nothing else
// a stalled result freezes the divider pipeline; the queue keeps taking
// pixels until it holds two
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  rgbhsv_pix_if.sink    pix_i,
  rgbhsv_hsv_if.source  hsv_o
);
  import rgbhsv_pkg::*;

  logic   push;
  logic   q_ready;
  logic   q_valid;
  logic   q_pop;
  entry_t front_entry;
  entry_t q_entry;

  rgbhsv_front u_front (
    .pix_i     (pix_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (front_entry)
  );

  rgbhsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  rgbhsv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .hsv_o     (hsv_o)
  );

  // black pixel has no saturation
  a_black_no_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && (hsv_o.value == '0) |-> (hsv_o.saturation == '0))
    else $error("black pixel with nonzero saturation");

  // zero saturation on a lit pixel means grey, so hue must be zero
  a_grey_no_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && (hsv_o.value != '0) && (hsv_o.saturation == '0)
      |-> (hsv_o.hue == '0))
    else $error("grey pixel with nonzero hue");

  // pixel held back only when the queue has something to drain
  a_stall_has_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && !pix_i.ready |-> q_valid)
    else $error("input stalled with empty queue");

  // a request leaving the queue must enter the divider pipeline next cycle
  a_pop_enters_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (u_back.vld_q[0] == 1'b1))
    else $error("queue pop lost before the dividers");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter testbench
// Feeds pixels through the valid/ready input channel and checks every hue,
// saturation and value result against a fixed-point predictor of the
// conversion or a typed result. A table of corner pixels runs first, then
// random pixels with idle bursts on both channels, a long output hold-off that
// backs up the pipeline, and one pause that lets the block drain completely.
// ----------------------------------------------------------------------------
module testbench;
  import rgbhsv_pkg::*;

  localparam int RANDOM_PIXELS  = 930;
  localparam int QUIET_TAIL     = 150;
  localparam int DRAIN_AT       = 600;
  localparam int LONG_HOLD_AT   = 250;
  localparam int LONG_HOLD_LEN  = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_CORNERS      = 20;

  typedef struct packed {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] saturation;
    logic [CH_W-1:0]  value;
  } hsv_t;

  // a pixel request on its way in, with a typed result where one is known
  typedef struct packed {
    bit   typed;
    hsv_t hsv;
  } pixel_offer_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    bit              typed;
    hsv_t            hsv;
  } corner_pixel_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  rgbhsv_pix_if pix ();
  rgbhsv_hsv_if hsv ();

  rgb_to_hsv_converter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .hsv_o  (hsv)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pixel_offer_t pixel_offers [$];
  hsv_t         hsv_expected [$];
  int           fail_count   = 0;
  int           results_seen = 0;
  int           quiet_cycles = 0;
  bit           tail_quiet   = 1'b0;

  corner_pixel_t corner_pixels [N_CORNERS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0, 16'd0,     8'd0}},    // black
    '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0, 16'd0,     8'd255}},  // white
    '{8'd1,   8'd1,   8'd1,   1'b1, '{16'd0, 16'd0,     8'd1}},    // grey
    '{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0, 16'd0,     8'd128}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0, 16'd65535, 8'd255}},  // full saturation
    '{8'd1,   8'd0,   8'd0,   1'b1, '{16'd0, 16'd65535, 8'd1}},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},  // red/green tie, green wins
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},  // green/blue tie, blue wins
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},  // red/blue tie, blue wins
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},  // just short of a full turn
    '{8'd255, 8'd1,   8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd254, 8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd128, 8'd0,   1'b0, '0},
    '{8'd1,   8'd2,   8'd3,   1'b0, '0},
    '{8'd200, 8'd100, 8'd150, 1'b0, '0},
    '{8'd85,  8'd170, 8'd255, 1'b0, '0}
  };

  function automatic hsv_t hsv_of_pixel(input logic [CH_W-1:0] red,
                                        input logic [CH_W-1:0] green,
                                        input logic [CH_W-1:0] blue);
    longint rr, gg, bb, top, bottom, span, sector, turn, h, s;
    hsv_t   res;
    rr = longint'(red);
    gg = longint'(green);
    bb = longint'(blue);
    top = rr;
    if (gg > top) top = gg;
    if (bb > top) top = bb;
    bottom = rr;
    if (gg < bottom) bottom = gg;
    if (bb < bottom) bottom = bb;
    span = top - bottom;
    turn = longint'(1) << FRAC_BITS;
    h = 0;
    s = 0;
    if (span != 0) begin
      // blue beats green beats red on a tie
      if (top == bb) begin
        sector = (rr - gg) + 4 * span;
      end else if (top == gg) begin
        sector = (bb - rr) + 2 * span;
      end else begin
        sector = gg - bb;
        if (gg < bb) sector += 6 * span;
      end
      h = ((2 * sector * turn + 6 * span) / (12 * span)) & (turn - 1);
    end
    if (top != 0) begin
      s = (2 * span * turn + top) / (2 * top);
      if (s > turn - 1) s = turn - 1;
    end
    res.hue        = h[OUT_W-1:0];
    res.saturation = s[OUT_W-1:0];
    res.value      = top[CH_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // both channels sampled at the edge, before any driven update lands
  always @(posedge clk_i) begin
    pixel_offer_t offer;
    hsv_t         want;
    if (rst_n) begin
      if (pix.valid && pix.ready) begin
        offer = pixel_offers.pop_front();
        hsv_expected.push_back(offer.typed ? offer.hsv
                               : hsv_of_pixel(pix.red, pix.green, pix.blue));
      end
      if (hsv.valid && hsv.ready) begin
        results_seen++;
        if (hsv_expected.size() == 0) begin
          $display("%0t: unexpected result hue %0d saturation %0d value %0d",
                   $time, hsv.hue, hsv.saturation, hsv.value);
          fail_count++;
        end else begin
          want = hsv_expected.pop_front();
          check_field("hue", int'(want.hue), int'(hsv.hue));
          check_field("saturation", int'(want.saturation), int'(hsv.saturation));
          check_field("value", int'(want.value), int'(hsv.value));
        end
      end
      if ((pix.valid && pix.ready) || (hsv.valid && hsv.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  task automatic offer_pixel(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                             input logic [CH_W-1:0] blue, input bit typed,
                             input hsv_t want, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pixel_offers.push_back('{typed, want});
    pix.valid <= 1'b1;
    pix.red   <= red;
    pix.green <= green;
    pix.blue  <= blue;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  task automatic pick_pixel(output logic [CH_W-1:0] red, output logic [CH_W-1:0] green,
                            output logic [CH_W-1:0] blue);
    int kind;
    int top;
    int other;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        red   = CH_W'($urandom_range(0, 255));
        green = red;
        blue  = red;
      end
      1: begin
        // two channels tie for largest
        top   = $urandom_range(0, 255);
        other = $urandom_range(0, top);
        case ($urandom_range(0, 2))
          0: begin red = CH_W'(top);   green = CH_W'(top);   blue = CH_W'(other); end
          1: begin red = CH_W'(other); green = CH_W'(top);   blue = CH_W'(top);   end
          default: begin red = CH_W'(top); green = CH_W'(other); blue = CH_W'(top); end
        endcase
      end
      2: begin
        red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      3: begin
        red   = CH_W'($urandom_range(0, 3));
        green = CH_W'($urandom_range(0, 3));
        blue  = CH_W'($urandom_range(0, 3));
      end
      default: begin
        red   = CH_W'($urandom_range(0, 255));
        green = CH_W'($urandom_range(0, 255));
        blue  = CH_W'($urandom_range(0, 255));
      end
    endcase
  endtask

  initial begin : stimulus
    logic [CH_W-1:0] red, green, blue;
    bit              may_idle;
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < N_CORNERS; i++) begin
      offer_pixel(corner_pixels[i].red, corner_pixels[i].green, corner_pixels[i].blue,
                  corner_pixels[i].typed, corner_pixels[i].hsv, 1'b1);
    end
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == DRAIN_AT) begin
        // let every outstanding request come out before going on
        pix.valid <= 1'b0;
        do @(posedge clk_i); while (hsv_expected.size() != 0 || pixel_offers.size() != 0);
      end
      if (n >= RANDOM_PIXELS - QUIET_TAIL) tail_quiet = 1'b1;
      may_idle = !tail_quiet && ((n / 64) % 3 != 0);
      pick_pixel(red, green, blue);
      offer_pixel(red, green, blue, 1'b0, '0, may_idle);
    end
    pix.valid <= 1'b0;
    do @(posedge clk_i); while (hsv_expected.size() != 0 || pixel_offers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("rgb_to_hsv_converter: match");
    end else begin
      $display("rgb_to_hsv_converter: mismatch");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    int cycle_no;
    bit long_hold_done;
    cycle_no = 0;
    long_hold_done = 1'b0;
    hsv.ready <= 1'b0;
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        // hold off long enough for the queue to fill and stall the input
        long_hold_done = 1'b1;
        hsv.ready <= 1'b0;
        repeat (LONG_HOLD_LEN) @(posedge clk_i);
      end else if (!tail_quiet && (cycle_no / 128) % 3 != 0 && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
        hsv.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      hsv.ready <= 1'b1;
      @(posedge clk_i);
      cycle_no++;
    end
  end

  initial begin : watchdog
    while (!rst_n) @(posedge clk_i);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("rgb_to_hsv_converter: mismatch");
    $finish;
  end

endmodule
